[hw/rtl/nmea_pkg.sv]
// shared types, constants and character codes for the nmea rmc position parser
// no dependencies

package nmea_pkg;

   localparam int FRACTION_DIGITS = 5;

   localparam int MAG_W = 31;
   localparam int SUM_W = 36;
   localparam logic [MAG_W-1:0] MAX_MAG = {MAG_W{1'b1}};

   localparam logic [2:0] FRAC_LAST = 3'(FRACTION_DIGITS - 1);
   localparam logic [2:0] FRAC_CNT  = 3'(FRACTION_DIGITS);
   localparam logic [2:0] TYPE_LEN  = 3'd5;

   localparam logic [23:0] TEN_POW [8] = '{
      24'd1, 24'd10, 24'd100, 24'd1000,
      24'd10000, 24'd100000, 24'd1000000, 24'd10000000
   };

   localparam logic [7:0] CHR_NL     = 8'd10;
   localparam logic [7:0] CHR_TAB    = 8'd9;
   localparam logic [7:0] CHR_CR     = 8'd13;
   localparam logic [7:0] CHR_SPACE  = 8'd32;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_COMMA  = 8'h2c;
   localparam logic [7:0] CHR_MINUS  = 8'h2d;
   localparam logic [7:0] CHR_PLUS   = 8'h2b;
   localparam logic [7:0] CHR_POINT  = 8'h2e;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_SOUTH  = 8'h53;
   localparam logic [7:0] CHR_WEST   = 8'h57;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_START = 2'd1;
   localparam logic [1:0] ST_OTHER     = 2'd2;
   localparam logic [1:0] ST_FIELD     = 2'd3;

   typedef enum logic [4:0] {
      PH_START,
      PH_TYPE,
      PH_TIME_PRE,
      PH_TIME_BODY,
      PH_STATUS_CHAR,
      PH_STATUS_COMMA,
      PH_LAT_PRE,
      PH_LAT_BODY,
      PH_LAT_DIR,
      PH_LAT_COMMA,
      PH_LON_PRE,
      PH_LON_BODY,
      PH_LON_DIR,
      PH_DONE,
      PH_DEAD
   } phase_type;

   typedef enum logic [1:0] {
      NUM_CONT,
      NUM_END,
      NUM_ERR
   } num_event_type;

   typedef struct packed {
      logic digit;
      logic neg;
      logic point;
   } num_flags_type;

   function automatic logic [7:0] type_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h47;
         3'd1: c = 8'h50;
         3'd2: c = 8'h52;
         3'd3: c = 8'h4d;
         3'd4: c = 8'h43;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/nmea_digit_acc.sv]
// one decimal digit step of the scaled number accumulator with saturation
// depends on nmea_pkg

module nmea_digit_acc
   import nmea_pkg::*;
(
   input  logic [MAG_W-1:0] acc,
   input  logic [3:0]       digit,
   input  logic             point_seen,
   input  logic [2:0]       frac_cnt,
   output logic [MAG_W-1:0] acc_next,
   output logic [2:0]       frac_cnt_next
);

   logic [SUM_W-1:0] acc_ext;
   logic [SUM_W-1:0] int_sum;
   logic [SUM_W-1:0] frac_sum;
   logic [SUM_W-1:0] sum;
   logic [27:0]      int_add;
   logic [27:0]      frac_add;
   logic [2:0]       frac_idx;

   assign acc_ext  = SUM_W'(acc);
   assign int_add  = 28'(digit) * 28'(TEN_POW[FRAC_CNT]);
   assign frac_idx = FRAC_LAST - frac_cnt;
   assign frac_add = 28'(digit) * 28'(TEN_POW[frac_idx]);
   assign int_sum  = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(int_add);
   assign frac_sum = acc_ext + SUM_W'(frac_add);

   always_comb begin
      frac_cnt_next = frac_cnt;
      sum           = acc_ext;
      if (point_seen) begin
         if (frac_cnt < FRAC_CNT) begin
            sum           = frac_sum;
            frac_cnt_next = frac_cnt + 3'd1;
         end
      end else begin
         sum = int_sum;
      end
      acc_next = (sum > SUM_W'(MAX_MAG)) ? MAX_MAG : sum[MAG_W-1:0];
   end

endmodule

[hw/rtl/nmea_rmc_position_parser.sv]
// top level of the nmea rmc position parser: input register, sentence state, result register
// depends on nmea_pkg and nmea_digit_acc

// Takes one text byte per clock while req_stall is low, and returns one word per newline holding
// the parse status and the signed latitude and longitude scaled by 10^FRACTION_DIGITS.
// A byte is registered in the input register and folded into the sentence state from there;
// the result of a newline is written to the result register as the newline leaves the input register.
// The result register lets bytes keep flowing while a result waits; req_stall rises only
// when a newline sits in the input register and the previous result is still stalled.

module nmea_rmc_position_parser
   import nmea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_parse_status,
   output logic [31:0] rsp_latitude_scaled,
   output logic [31:0] rsp_longitude_scaled
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               fire;
   logic               is_nl;

   phase_type          phase_ff, phase_in;
   logic [2:0]         type_cnt_ff, type_cnt_in;
   logic [MAG_W-1:0]   acc_ff, acc_in;
   logic [2:0]         frac_cnt_ff, frac_cnt_in;
   num_flags_type      flags_ff, flags_in;
   logic [31:0]        lat_ff, lat_in;
   logic [31:0]        lon_ff, lon_in;
   logic [1:0]         err_ff, err_in;

   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_status_ff, out_status_in;
   logic [31:0]        out_lat_ff, out_lat_in;
   logic [31:0]        out_lon_ff, out_lon_in;

   logic [MAG_W-1:0]   acc_digit;
   logic [2:0]         frac_cnt_digit;
   logic               is_blank, is_digit, is_pre, is_body;
   num_event_type      num_ev;
   logic [31:0]        num_value;
   logic [1:0]         nl_status;
   logic               type_fail;

   // input side
   assign is_nl     = in_byte_ff == CHR_NL;
   assign fire      = in_valid_ff && !(is_nl && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
      end
   end

   // number field decoding
   assign is_blank = (in_byte_ff == CHR_SPACE) ||
                     (in_byte_ff >= CHR_TAB && in_byte_ff <= CHR_CR);
   assign is_digit = (in_byte_ff >= CHR_ZERO) && (in_byte_ff <= CHR_NINE);
   assign is_pre   = (phase_ff == PH_TIME_PRE) || (phase_ff == PH_LAT_PRE) ||
                     (phase_ff == PH_LON_PRE);
   assign is_body  = (phase_ff == PH_TIME_BODY) || (phase_ff == PH_LAT_BODY) ||
                     (phase_ff == PH_LON_BODY);
   assign num_value = flags_ff.neg ? (32'd0 - {1'b0, acc_ff}) : {1'b0, acc_ff};

   nmea_digit_acc u_digit (
      .acc           (acc_ff),
      .digit         (4'(in_byte_ff - CHR_ZERO)),
      .point_seen    (flags_ff.point),
      .frac_cnt      (frac_cnt_ff),
      .acc_next      (acc_digit),
      .frac_cnt_next (frac_cnt_digit)
   );

   always_comb begin
      num_ev = NUM_CONT;
      if (!(is_pre && (is_blank || in_byte_ff == CHR_MINUS || in_byte_ff == CHR_PLUS))) begin
         if (is_digit) begin
            num_ev = NUM_CONT;
         end else if (in_byte_ff == CHR_POINT && !flags_ff.point) begin
            num_ev = NUM_CONT;
         end else if (in_byte_ff == CHR_COMMA && flags_ff.digit) begin
            num_ev = NUM_END;
         end else begin
            num_ev = NUM_ERR;
         end
      end
   end

   assign type_fail = !(in_byte_ff == CHR_COMMA && type_cnt_ff == TYPE_LEN) &&
                      !(in_byte_ff != CHR_COMMA && type_cnt_ff < TYPE_LEN &&
                        in_byte_ff == type_char(type_cnt_ff));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (is_nl) begin
            phase_in = PH_START;
         end else begin
            case (phase_ff)
               PH_START: begin
                  phase_in = (in_byte_ff == CHR_DOLLAR) ? PH_TYPE : PH_DEAD;
               end
               PH_TYPE: begin
                  if (type_fail) begin
                     phase_in = PH_DEAD;
                  end else if (in_byte_ff == CHR_COMMA) begin
                     phase_in = PH_TIME_PRE;
                  end
               end
               PH_TIME_PRE, PH_TIME_BODY: begin
                  if (num_ev == NUM_ERR) begin
                     phase_in = PH_DEAD;
                  end else if (num_ev == NUM_END) begin
                     phase_in = PH_STATUS_CHAR;
                  end else if (!(is_pre && is_blank)) begin
                     phase_in = PH_TIME_BODY;
                  end
               end
               PH_STATUS_CHAR: begin
                  phase_in = PH_STATUS_COMMA;
               end
               PH_STATUS_COMMA: begin
                  phase_in = (in_byte_ff == CHR_COMMA) ? PH_LAT_PRE : PH_DEAD;
               end
               PH_LAT_PRE, PH_LAT_BODY: begin
                  if (num_ev == NUM_ERR) begin
                     phase_in = PH_DEAD;
                  end else if (num_ev == NUM_END) begin
                     phase_in = PH_LAT_DIR;
                  end else if (!(is_pre && is_blank)) begin
                     phase_in = PH_LAT_BODY;
                  end
               end
               PH_LAT_DIR: begin
                  phase_in = PH_LAT_COMMA;
               end
               PH_LAT_COMMA: begin
                  phase_in = (in_byte_ff == CHR_COMMA) ? PH_LON_PRE : PH_DEAD;
               end
               PH_LON_PRE, PH_LON_BODY: begin
                  if (num_ev == NUM_ERR) begin
                     phase_in = PH_DEAD;
                  end else if (num_ev == NUM_END) begin
                     phase_in = PH_LON_DIR;
                  end else if (!(is_pre && is_blank)) begin
                     phase_in = PH_LON_BODY;
                  end
               end
               PH_LON_DIR: begin
                  phase_in = PH_DONE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // newline status
   always_comb begin
      case (phase_ff)
         PH_DONE:  nl_status = ST_OK;
         PH_DEAD:  nl_status = err_ff;
         PH_START: nl_status = ST_BAD_START;
         PH_TYPE: begin
            if (type_cnt_ff == 3'd0) begin
               nl_status = ST_BAD_START;
            end else if (type_cnt_ff == TYPE_LEN) begin
               nl_status = ST_FIELD;
            end else begin
               nl_status = ST_OTHER;
            end
         end
         default:  nl_status = ST_FIELD;
      endcase
   end

   // datapath updates
   always_comb begin
      type_cnt_in  = type_cnt_ff;
      acc_in       = acc_ff;
      frac_cnt_in  = frac_cnt_ff;
      flags_in     = flags_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      err_in       = err_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_lat_in    = out_lat_ff;
      out_lon_in    = out_lon_ff;
      if (fire) begin
         if (is_nl) begin
            out_valid_in  = 1'b1;
            out_status_in = nl_status;
            out_lat_in    = (nl_status == ST_OK) ? lat_ff : 32'd0;
            out_lon_in    = (nl_status == ST_OK) ? lon_ff : 32'd0;
            type_cnt_in   = 3'd0;
            acc_in        = '0;
            frac_cnt_in   = 3'd0;
            flags_in      = '0;
            lat_in        = 32'd0;
            lon_in        = 32'd0;
            err_in        = ST_OK;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (in_byte_ff != CHR_DOLLAR) begin
                     err_in = ST_BAD_START;
                  end
               end
               PH_TYPE: begin
                  if (type_fail) begin
                     err_in = (in_byte_ff == CHR_COMMA && type_cnt_ff == 3'd0) ?
                              ST_BAD_START : ST_OTHER;
                  end else if (in_byte_ff == CHR_COMMA) begin
                     acc_in      = '0;
                     frac_cnt_in = 3'd0;
                     flags_in    = '0;
                  end else begin
                     type_cnt_in = type_cnt_ff + 3'd1;
                  end
               end
               PH_TIME_PRE, PH_TIME_BODY, PH_LAT_PRE, PH_LAT_BODY,
               PH_LON_PRE, PH_LON_BODY: begin
                  if (num_ev == NUM_ERR) begin
                     err_in = ST_FIELD;
                  end else if (num_ev == NUM_END) begin
                     if (phase_ff == PH_LAT_PRE || phase_ff == PH_LAT_BODY) begin
                        lat_in = num_value;
                     end
                     if (phase_ff == PH_LON_PRE || phase_ff == PH_LON_BODY) begin
                        lon_in = num_value;
                     end
                  end else if (is_pre && in_byte_ff == CHR_MINUS) begin
                     flags_in.neg = 1'b1;
                  end else if (is_pre && (is_blank || in_byte_ff == CHR_PLUS)) begin
                     flags_in = flags_ff;
                  end else if (is_digit) begin
                     acc_in         = acc_digit;
                     frac_cnt_in    = frac_cnt_digit;
                     flags_in.digit = 1'b1;
                  end else begin
                     flags_in.point = 1'b1;
                  end
               end
               PH_STATUS_COMMA, PH_LAT_COMMA: begin
                  if (in_byte_ff == CHR_COMMA) begin
                     acc_in      = '0;
                     frac_cnt_in = 3'd0;
                     flags_in    = '0;
                  end else begin
                     err_in = ST_FIELD;
                  end
               end
               PH_LAT_DIR: begin
                  if (in_byte_ff == CHR_SOUTH) begin
                     lat_in = 32'd0 - lat_ff;
                  end
               end
               PH_LON_DIR: begin
                  if (in_byte_ff == CHR_WEST) begin
                     lon_in = 32'd0 - lon_ff;
                  end
               end
               default: begin
                  err_in = err_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         type_cnt_ff  <= 3'd0;
         acc_ff       <= '0;
         frac_cnt_ff  <= 3'd0;
         flags_ff     <= '0;
         lat_ff       <= 32'd0;
         lon_ff       <= 32'd0;
         err_ff       <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         type_cnt_ff  <= type_cnt_in;
         acc_ff       <= acc_in;
         frac_cnt_ff  <= frac_cnt_in;
         flags_ff     <= flags_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
      out_status_ff <= out_status_in;
      out_lat_ff    <= out_lat_in;
      out_lon_ff    <= out_lon_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_parse_status     = out_status_ff;
   assign rsp_latitude_scaled  = out_lat_ff;
   assign rsp_longitude_scaled = out_lon_ff;

endmodule

[hw/rtl/nmea_chk.sv]
// port-level checker for the nmea rmc position parser, bound to the top level
// depends on nmea_pkg

module nmea_chk
   import nmea_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_text_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_parse_status,
   input logic [31:0] rsp_latitude_scaled,
   input logic [31:0] rsp_longitude_scaled
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_parse_status) &&
         $stable(rsp_latitude_scaled) && $stable(rsp_longitude_scaled))
      else $error("stalled result word changed");

   // positions are zero unless the sentence parsed
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_status != ST_OK |->
         rsp_latitude_scaled == 32'd0 && rsp_longitude_scaled == 32'd0)
      else $error("nonzero position on failed sentence");

   // a fresh result word follows a newline that was taken through the input register
   a_result_from_newline: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_text_byte == CHR_NL, 2))
      else $error("result word without a newline");

   // the input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no waiting result");

endmodule

bind nmea_rmc_position_parser nmea_chk u_nmea_chk (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .req_text_byte        (req_text_byte),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_parse_status     (rsp_parse_status),
   .rsp_latitude_scaled  (rsp_latitude_scaled),
   .rsp_longitude_scaled (rsp_longitude_scaled)
);

[tb/nmea_rmc_position_parser_test.sv]
// self-checking bench for nmea_rmc_position_parser: directed and random lines, one byte per word
// predicts status and scaled latitude and longitude for every newline and checks rsp words in order
// depends on nmea_pkg and the parser rtl

`timescale 1ns / 100ps

module nmea_rmc_position_parser_test;
   import nmea_pkg::*;

   localparam int RANDOM_BYTES = 780;
   localparam int CALM_BYTES   = 150;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [63:0] SAT_MAG = 64'h7fff_ffff;
   localparam logic [7:0] RMC_TAG [5] = '{"G", "P", "R", "M", "C"};
   localparam logic [7:0] BLANKS [5] = '{CHR_TAB, 8'd11, 8'd12, CHR_CR, CHR_SPACE};

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] lat;
      logic [31:0] lon;
   } fix_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_parse_status;
   logic [31:0] rsp_latitude_scaled;
   logic [31:0] rsp_longitude_scaled;

   nmea_rmc_position_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_text_byte        (req_text_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_parse_status     (rsp_parse_status),
      .rsp_latitude_scaled  (rsp_latitude_scaled),
      .rsp_longitude_scaled (rsp_longitude_scaled)
   );

   logic [7:0]   pending [$];
   logic [7:0]   sentence_bytes [$];
   fix_word_type fix_words_due [$];
   fix_word_type want;

   int errors = 0;
   int bytes_taken = 0;
   int input_stalls = 0;
   int status_tally [4] = '{0, 0, 0, 0};
   bit calm = 1'b0;

   // parser state mirror
   phase_type   parse_at = PH_START;
   logic [2:0]  type_seen = '0;
   logic [31:0] acc = '0;
   logic [2:0]  frac_seen = '0;
   logic        num_digit = 1'b0;
   logic        num_neg = 1'b0;
   logic        num_point = 1'b0;
   logic [31:0] lat_hold = '0;
   logic [31:0] lon_hold = '0;
   logic [1:0]  err_hold = '0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] decade(input int n);
      logic [63:0] p;
      p = 64'd1;
      repeat (n) p = p * 64'd10;
      return p;
   endfunction

   function automatic void clear_number();
      acc = '0;
      frac_seen = '0;
      num_digit = 1'b0;
      num_neg = 1'b0;
      num_point = 1'b0;
   endfunction

   function automatic void abandon(input logic [1:0] code);
      err_hold = code;
      parse_at = PH_DEAD;
   endfunction

   function automatic num_event_type number_char(input logic [7:0] c, input phase_type pre);
      logic [63:0] sum;
      logic [63:0] d;
      if (parse_at == pre) begin
         if (c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR))
            return NUM_CONT;
         parse_at = phase_type'(pre + 5'd1);
         if (c == CHR_MINUS) begin
            num_neg = 1'b1;
            return NUM_CONT;
         end
         if (c == CHR_PLUS)
            return NUM_CONT;
      end
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
         d = 64'(c - CHR_ZERO);
         if (num_point) begin
            if (frac_seen < FRACTION_DIGITS) begin
               sum = 64'(acc) + d * decade(FRACTION_DIGITS - 1 - int'(frac_seen));
               frac_seen = frac_seen + 3'd1;
            end else begin
               sum = 64'(acc);
            end
         end else begin
            sum = 64'(acc) * 64'd10 + d * decade(FRACTION_DIGITS);
         end
         acc = (sum > SAT_MAG) ? SAT_MAG[31:0] : sum[31:0];
         num_digit = 1'b1;
         return NUM_CONT;
      end
      if (c == CHR_POINT && !num_point) begin
         num_point = 1'b1;
         return NUM_CONT;
      end
      if (c == CHR_COMMA && num_digit)
         return NUM_END;
      return NUM_ERR;
   endfunction

   function automatic void parse_byte(input logic [7:0] c);
      fix_word_type w;
      num_event_type ev;
      if (c == CHR_NL) begin
         case (parse_at)
            PH_DONE:  w.status = ST_OK;
            PH_DEAD:  w.status = err_hold;
            PH_START: w.status = ST_BAD_START;
            PH_TYPE:  w.status = (type_seen == 3'd0) ? ST_BAD_START :
                                 (type_seen == TYPE_LEN) ? ST_FIELD : ST_OTHER;
            default:  w.status = ST_FIELD;
         endcase
         w.lat = (w.status == ST_OK) ? lat_hold : '0;
         w.lon = (w.status == ST_OK) ? lon_hold : '0;
         fix_words_due.push_back(w);
         status_tally[w.status]++;
         parse_at = PH_START;
         type_seen = '0;
         clear_number();
         lat_hold = '0;
         lon_hold = '0;
         err_hold = '0;
         return;
      end
      case (parse_at)
         PH_START: begin
            if (c == CHR_DOLLAR) parse_at = PH_TYPE;
            else abandon(ST_BAD_START);
         end
         PH_TYPE: begin
            if (c == CHR_COMMA) begin
               if (type_seen == 3'd0) begin
                  abandon(ST_BAD_START);
               end else if (type_seen == TYPE_LEN) begin
                  clear_number();
                  parse_at = PH_TIME_PRE;
               end else begin
                  abandon(ST_OTHER);
               end
            end else if (type_seen < TYPE_LEN && c == RMC_TAG[type_seen]) begin
               type_seen = type_seen + 3'd1;
            end else begin
               abandon(ST_OTHER);
            end
         end
         PH_TIME_PRE, PH_TIME_BODY: begin
            ev = number_char(c, PH_TIME_PRE);
            if (ev == NUM_END) parse_at = PH_STATUS_CHAR;
            else if (ev == NUM_ERR) abandon(ST_FIELD);
         end
         PH_STATUS_CHAR: parse_at = PH_STATUS_COMMA;
         PH_STATUS_COMMA: begin
            if (c == CHR_COMMA) begin
               clear_number();
               parse_at = PH_LAT_PRE;
            end else begin
               abandon(ST_FIELD);
            end
         end
         PH_LAT_PRE, PH_LAT_BODY: begin
            ev = number_char(c, PH_LAT_PRE);
            if (ev == NUM_END) begin
               lat_hold = num_neg ? -acc : acc;
               parse_at = PH_LAT_DIR;
            end else if (ev == NUM_ERR) begin
               abandon(ST_FIELD);
            end
         end
         PH_LAT_DIR: begin
            if (c == CHR_SOUTH) lat_hold = -lat_hold;
            parse_at = PH_LAT_COMMA;
         end
         PH_LAT_COMMA: begin
            if (c == CHR_COMMA) begin
               clear_number();
               parse_at = PH_LON_PRE;
            end else begin
               abandon(ST_FIELD);
            end
         end
         PH_LON_PRE, PH_LON_BODY: begin
            ev = number_char(c, PH_LON_PRE);
            if (ev == NUM_END) begin
               lon_hold = num_neg ? -acc : acc;
               parse_at = PH_LON_DIR;
            end else if (ev == NUM_ERR) begin
               abandon(ST_FIELD);
            end
         end
         PH_LON_DIR: begin
            if (c == CHR_WEST) lon_hold = -lon_hold;
            parse_at = PH_DONE;
         end
         default: ;
      endcase
   endfunction

   // sentence text builders
   function automatic logic [7:0] any_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CHR_NL) ? CHR_NL + 8'd1 : b;
   endfunction

   task add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) sentence_bytes.push_back(8'(s[i]));
   endtask

   task end_line();
      sentence_bytes.push_back(CHR_NL);
      foreach (sentence_bytes[i]) pending.push_back(sentence_bytes[i]);
      sentence_bytes.delete();
   endtask

   task add_number();
      int lead, whole, frac, k;
      lead = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      whole = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 5);
      frac = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (whole == 0 && frac == 0) whole = 1;
      for (k = 0; k < lead; k++) sentence_bytes.push_back(BLANKS[$urandom_range(0, 4)]);
      case ($urandom_range(0, 5))
         0: sentence_bytes.push_back(CHR_MINUS);
         1: sentence_bytes.push_back(CHR_PLUS);
         default: ;
      endcase
      for (k = 0; k < whole; k++) sentence_bytes.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
      if (frac != 0 || $urandom_range(0, 5) == 0) sentence_bytes.push_back(CHR_POINT);
      for (k = 0; k < frac; k++) sentence_bytes.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task add_rmc();
      add_text("$GPRMC,");
      add_number();
      sentence_bytes.push_back(CHR_COMMA);
      if ($urandom_range(0, 3) == 0) sentence_bytes.push_back(any_byte());
      else add_text($urandom_range(0, 1) ? "A" : "V");
      sentence_bytes.push_back(CHR_COMMA);
      add_number();
      sentence_bytes.push_back(CHR_COMMA);
      if ($urandom_range(0, 5) == 0) sentence_bytes.push_back(any_byte());
      else sentence_bytes.push_back($urandom_range(0, 1) ? CHR_SOUTH : 8'(78));
      sentence_bytes.push_back(CHR_COMMA);
      add_number();
      sentence_bytes.push_back(CHR_COMMA);
      if ($urandom_range(0, 5) == 0) sentence_bytes.push_back(any_byte());
      else sentence_bytes.push_back($urandom_range(0, 1) ? CHR_WEST : 8'(69));
      if ($urandom_range(0, 1)) begin
         add_text("*5C");
         sentence_bytes.push_back(CHR_CR);
      end
   endtask

   task add_sentence();
      int pick, k;
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
         if ($urandom_range(0, 1)) sentence_bytes.push_back(CHR_DOLLAR);
         repeat ($urandom_range(0, 10)) sentence_bytes.push_back(any_byte());
      end else begin
         add_rmc();
         if (pick == 6) begin
            k = $urandom_range(0, sentence_bytes.size() - 1);
            while (sentence_bytes.size() > k) void'(sentence_bytes.pop_back());
         end else if (pick >= 7) begin
            k = $urandom_range(0, 1) ? $urandom_range(0, 6)
                                     : $urandom_range(0, sentence_bytes.size() - 1);
            sentence_bytes[k] = any_byte();
         end
      end
      end_line();
   endtask

   // stimulus, end of run
   initial begin
      int total;
      end_line();
      add_text(","); end_line();
      add_text("$"); end_line();
      add_text("$,"); end_line();
      add_text("$GPGGA,1"); end_line();
      add_text("$GPRMCC,"); end_line();
      add_text("$GPRM"); end_line();
      add_text("$GPRMC"); end_line();
      add_text("$$GPRMC"); end_line();
      add_text("$GPRMC,123519,A,4807.038,N,01131.000,E*6A");
      sentence_bytes.push_back(CHR_CR);
      end_line();
      add_text("$GPRMC,");
      foreach (BLANKS[i]) sentence_bytes.push_back(BLANKS[i]);
      add_text("-.5,");
      sentence_bytes.push_back(8'hff);
      add_text(",-4807.0381299,S,+99999999999.9,W");
      end_line();
      add_text("$GPRMC,5.,V,0,S,21474.83647,W$,"); end_line();
      add_text("$GPRMC,1,A,21474.83648,N,-2147483648,W"); end_line();
      add_text("$GPRMC,1e5,A,1,N,1,E"); end_line();
      add_text("$GPRMC,1,A,1,N"); end_line();
      add_text("$GPRMC,,A,1,N,1,E"); end_line();
      add_text("$GPRMC,1,A,.,N,1,E"); end_line();
      add_text("$GPRMC,1,A,1.2.3,N,1,E"); end_line();
      add_text("$GPRMC,1,AB,1,N,1,E"); end_line();
      add_text("$GPRMC,1,A,- 1,N,1,E"); end_line();
      add_text("$GPRMC,1,A,1,NN,1,E"); end_line();
      add_text("$GPRMC,1,A,1,N,1 ,E"); end_line();
      add_text("$GP");
      sentence_bytes.push_back(8'h00);
      sentence_bytes.push_back(8'hff);
      end_line();
      sentence_bytes.push_back(8'h80);
      sentence_bytes.push_back(8'h7f);
      add_text("$GPRMC,1,A,1,N,1,E");
      end_line();
      total = pending.size() + RANDOM_BYTES;
      while (pending.size() < total) add_sentence();
      total = pending.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (bytes_taken < total || fix_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes: %0d ok, %0d bad start, %0d other type, %0d field error lines",
               bytes_taken, status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
      $display("one %0d-cycle rsp hold-off; req stalled on %0d cycles", HOLD_CYCLES, input_stalls);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // req driver
   int send_gap = 0;
   int send_mode_left = 0;
   bit send_idle = 1'b0;

   always @(posedge clock) begin
      if (!reset) begin
         if (send_mode_left == 0) begin
            send_mode_left = $urandom_range(40, 300);
            send_idle = ($urandom_range(0, 2) != 0);
         end else begin
            send_mode_left--;
         end
         if (req_valid && req_stall) input_stalls++;
         if (req_valid && !req_stall) begin
            parse_byte(req_text_byte);
            bytes_taken++;
         end
         calm = (pending.size() < CALM_BYTES);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               req_valid <= 1'b1;
               req_text_byte <= pending.pop_front();
               if (send_idle && !calm && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // rsp stall control
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_left = 0;
   int recv_mode_left = 0;
   bit recv_idle = 1'b0;

   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && bytes_taken >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (recv_mode_left == 0) begin
            recv_mode_left = $urandom_range(40, 300);
            recv_idle = ($urandom_range(0, 2) != 0);
         end else begin
            recv_mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (recv_idle && !calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // rsp monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fix_words_due.size() == 0) begin
            $error("unexpected rsp word: status %0d", rsp_parse_status);
            errors++;
         end else begin
            want = fix_words_due.pop_front();
            if (rsp_parse_status !== want.status) begin
               $error("parse_status: expected %0d, got %0d", want.status, rsp_parse_status);
               errors++;
            end
            if (rsp_latitude_scaled !== want.lat) begin
               $error("latitude_scaled: expected %0d, got %0d",
                      $signed(want.lat), $signed(rsp_latitude_scaled));
               errors++;
            end
            if (rsp_longitude_scaled !== want.lon) begin
               $error("longitude_scaled: expected %0d, got %0d",
                      $signed(want.lon), $signed(rsp_longitude_scaled));
               errors++;
            end
         end
      end
   end

endmodule
